[rtl/sacl_pkg.sv]
// Package: constants and types for the set-associative LRU tracker.
`default_nettype none
package sacl_pkg;
	localparam int DEF_MAX_SETS   = 256;
	localparam int DEF_MAX_WAYS   = 8;
	localparam int DEF_ADDR_WIDTH = 64;
	localparam int TAG_W          = 62;
	localparam int CNT_W          = 32;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_STORE  = 2'd1,
		CMD_MODIFY = 2'd2,
		CMD_RSVD   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_SET_BITS   = 2'd0,
		REG_BLOCK_BITS = 2'd1,
		REG_WAYS       = 2'd2,
		REG_NONE       = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

[rtl/set_assoc_cache_lru_tracker.sv]
// Top level: set-associative cache tag tracker with true LRU replacement.
// An accepted transaction has its set read, then its update in LOOKUP; the result shows in OUT.
// A new transaction is accepted only in IDLE, once the previous result has been taken.
// Set memory is one synchronous RAM, one row per set; a clearing pass over all sets
// follows reset, during which in_stall is high. Counters, config and state reset at once.
`default_nettype none
module set_assoc_cache_lru_tracker import sacl_pkg::*; #(
	parameter int MAX_SETS   = DEF_MAX_SETS,
	parameter int MAX_WAYS   = DEF_MAX_WAYS,
	parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [1:0]            command,
	input  wire logic [ADDR_WIDTH-1:0] address,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       was_hit,
	output logic                       was_miss,
	output logic                       was_evicted,
	output logic                       second_hit,
	output logic [CNT_W-1:0]           hits_total,
	output logic [CNT_W-1:0]           misses_total,
	output logic [CNT_W-1:0]           evictions_total,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [4:0]            cfg_data
);
	localparam int SET_AW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int RW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WAYW   = $clog2(MAX_WAYS + 1);
	localparam int LINE_W = 1 + TAG_W + RW;
	localparam int ROW_W  = MAX_WAYS * LINE_W;
	localparam logic [RW-1:0] RMAX = RW'(MAX_WAYS - 1);

	typedef struct packed {
		logic          vld;
		logic [TAG_W-1:0] tag;
		logic [RW-1:0] rec;
	} line_t;

	logic [ROW_W-1:0] mem [MAX_SETS];
	logic [ROW_W-1:0] rd_q;
	logic [ROW_W-1:0] wr_row;
	logic             we;
	logic [SET_AW-1:0] wr_addr, rd_addr;

	state_t state_q, state_d;
	logic [SET_AW:0] clr_q;
	logic [3:0] set_bits_q;
	logic [4:0] block_bits_q;
	logic [3:0] ways_q;
	logic [1:0] cmd_q;
	logic [SET_AW-1:0] set_q;
	logic [TAG_W-1:0] tag_q;

	logic [4:0]  sb, bb;
	logic [WAYW-1:0] nw;
	logic [ADDR_WIDTH-1:0] ash;
	logic [SET_AW-1:0] set_c;
	logic [TAG_W-1:0] tag_c;

	line_t l_in  [MAX_WAYS];
	line_t l_out [MAX_WAYS];
	logic hit, have_free, evict;
	logic [RW-1:0] found, hitw, freew, lruw, best, old;
	logic [CNT_W-1:0] hits_n, miss_n, evi_n;

	assign cfg_ready = (state_q != ST_LOOKUP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= 4'd1;
			block_bits_q <= 5'd1;
			ways_q       <= 4'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SET_BITS:   set_bits_q   <= cfg_data[3:0];
				REG_BLOCK_BITS: block_bits_q <= cfg_data;
				REG_WAYS:       ways_q       <= cfg_data[3:0];
				REG_NONE:       ;
			endcase
		end
	end

	always_comb begin
		sb = {1'b0, set_bits_q};
		if (sb < 5'd1) sb = 5'd1;
		if (32'(sb) > SET_AW) sb = 5'(SET_AW);
		bb = block_bits_q;
		if (bb < 5'd1) bb = 5'd1;
		if (bb > 5'd16) bb = 5'd16;
		nw = WAYW'(ways_q);
		if (32'(ways_q) > MAX_WAYS) nw = WAYW'(MAX_WAYS);
		if (ways_q == 4'd0) nw = WAYW'(1);
		ash   = address >> bb;
		set_c = SET_AW'(ash) & SET_AW'((32'd1 << sb) - 32'd1);
		tag_c = TAG_W'(ash >> sb);
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (clr_q == (SET_AW+1)'(MAX_SETS - 1)) state_d = ST_IDLE;
			ST_IDLE:   if (in_valid) state_d = ST_LOOKUP;
			ST_LOOKUP: state_d = ST_OUT;
			ST_OUT:    if (!out_stall) state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cmd_q <= command;
			set_q <= set_c;
			tag_q <= tag_c;
		end
	end

	assign rd_addr = set_c;
	always_ff @(posedge clk) begin
		if (we) mem[wr_addr] <= wr_row;
		rd_q <= mem[rd_addr];
	end

	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) l_in[w] = line_t'(rd_q[w*LINE_W +: LINE_W]);
		hit = 1'b0; hitw = '0;
		for (int w = MAX_WAYS-1; w >= 0; w--)
			if (w < 32'(nw) && l_in[w].vld && l_in[w].tag == tag_q) begin
				hit = 1'b1; hitw = RW'(w);
			end
		have_free = 1'b0; freew = '0;
		for (int w = MAX_WAYS-1; w >= 0; w--)
			if (w < 32'(nw) && !l_in[w].vld) begin
				have_free = 1'b1; freew = RW'(w);
			end
		best = '0; lruw = '0;
		for (int w = 0; w < MAX_WAYS; w++)
			if (w < 32'(nw) && l_in[w].rec > best) begin
				best = l_in[w].rec; lruw = RW'(w);
			end
		evict = !hit && !have_free;
		found = hit ? hitw : (have_free ? freew : lruw);
		old = l_in[found].rec;
		for (int w = 0; w < MAX_WAYS; w++) begin
			l_out[w] = l_in[w];
			if (w < 32'(nw) && RW'(w) != found && l_in[w].vld &&
			    (!l_in[found].vld || l_in[w].rec < old) && l_in[w].rec < RMAX)
				l_out[w].rec = l_in[w].rec + 1'b1;
		end
		l_out[found].vld = 1'b1;
		l_out[found].tag = tag_q;
		l_out[found].rec = '0;
		we = 1'b0; wr_addr = set_q; wr_row = '0;
		if (state_q == ST_CLEAR) begin
			we = 1'b1; wr_addr = SET_AW'(clr_q);
		end else if (state_q == ST_LOOKUP) begin
			we = 1'b1;
			for (int w = 0; w < MAX_WAYS; w++) wr_row[w*LINE_W +: LINE_W] = l_out[w];
		end
	end

	always_comb begin
		hits_n = hits_total;
		miss_n = misses_total;
		evi_n  = evictions_total;
		if (hit && hits_n != '1) hits_n = hits_n + 1'b1;
		if (!hit && miss_n != '1) miss_n = miss_n + 1'b1;
		if (evict && evi_n != '1) evi_n = evi_n + 1'b1;
		if (cmd_t'(cmd_q) == CMD_MODIFY && hits_n != '1) hits_n = hits_n + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_total      <= '0;
			misses_total    <= '0;
			evictions_total <= '0;
		end else if (state_q == ST_LOOKUP) begin
			hits_total      <= hits_n;
			misses_total    <= miss_n;
			evictions_total <= evi_n;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOOKUP) begin
			was_hit     <= hit;
			was_miss    <= !hit;
			was_evicted <= evict;
			second_hit  <= (cmd_t'(cmd_q) == CMD_MODIFY);
		end
	end

	always_comb out_valid = (state_q == ST_OUT);
endmodule
`default_nettype wire

[rtl/sacl_checker.sv]
// Checker: port-level properties of the LRU tracker, bound to the top level.
`default_nettype none
module sacl_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        was_hit,
	input wire logic        was_miss,
	input wire logic        was_evicted,
	input wire logic [31:0] hits_total,
	input wire logic [31:0] misses_total
);
	a_hit_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (was_hit != was_miss)) else $error("hit and miss not exclusive");
	a_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_evicted |-> was_miss) else $error("evict without miss");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open while result pending");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && !out_valid)
		else $error("input open or result early after accepted transaction");
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hits_total) && $stable(misses_total))
		else $error("stalled result changed");
endmodule

bind set_assoc_cache_lru_tracker sacl_checker u_sacl_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .was_hit(was_hit),
	.was_miss(was_miss), .was_evicted(was_evicted), .hits_total(hits_total),
	.misses_total(misses_total)
);
`default_nettype wire
